// ===== hdl/crang_pkg.sv =====
package crang_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int SKEW_W   = 16;
    localparam int ANGLE_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Calibration datapath widths, derived from the field widths
    localparam int DIFF_W = SAMPLE_W + 1;              // sample - offset
    localparam int PROD_W = DIFF_W + GAIN_W + 1;       // diff * gain
    localparam int GAIN_SHIFT = 16;
    localparam int X_W    = PROD_W - GAIN_SHIFT;       // scaled channel
    localparam int Q_W    = X_W + SKEW_W;              // x * sin_skew
    localparam int FRAC_W = 14;                        // Q.14 fraction bits
    localparam int D_W    = Q_W + 1;                   // y * 2^14 - x * sin_skew
    localparam int T_W    = D_W - FRAC_W;
    localparam int M_W    = T_W + SKEW_W + 1;          // t * sec_skew
    localparam int YC_W   = M_W - FRAC_W;              // corrected sine channel

    // CORDIC datapath
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CW     = YC_W + 2;                  // room for fold and CORDIC growth
    localparam int ZW     = 32;                        // 2^32 stands for 2pi
    localparam logic [ZW-1:0] Z_HALF  = {1'b1, {(ZW-1){1'b0}}};
    localparam logic [ZW-1:0] Z_ROUND = ZW'(1) << (ZW - ANGLE_W - 1);

    // Request queue between calibration and CORDIC
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Cycles from an accepted start to its done strobe
    localparam int LATENCY = NSTEPS + 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_GAIN_X   = 3'd2,
        REG_GAIN_Y   = 3'd3,
        REG_SIN_SKEW = 3'd4,
        REG_SEC_SKEW = 3'd5,
        REG_PHASE_X  = 3'd6
    } crang_reg_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] offset_x;
        logic signed [SAMPLE_W-1:0] offset_y;
        logic [GAIN_W-1:0]          gain_x;
        logic [GAIN_W-1:0]          gain_y;
        logic signed [SKEW_W-1:0]   sin_skew;
        logic [SKEW_W-1:0]          sec_skew;
        logic [ANGLE_W-1:0]         phase_x;
    } crang_cfg_t;

    // One calibrated vector, already folded into the right half plane
    typedef struct packed {
        logic                 zero;
        logic                 half;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } crang_vec_t;

    function automatic logic [ZW-1:0] atan_lut(input logic [4:0] idx);
        logic [ZW-1:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/calibrated_resolver_angle.sv =====
// Channel   Handshake            Payload
// --------  -------------------  ------------------------------------------
// request   start / busy         cos_sample, sin_sample
// result    done (one cycle)     angle
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is taken per cycle; done follows the accepting edge through
// 5 calibration stages, the queue, the CORDIC stages and the output register,
// the CORDIC step count capped at 24.
// The receiver cannot stall, so the queue drains every cycle and busy stays low.
// Reset clears the pipeline valids, the queue and all calibration registers
// to their defaults; cfg_ready is always high.
module calibrated_resolver_angle
    import crang_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] cos_sample,
    input  logic signed [SAMPLE_W-1:0] sin_sample,
    output logic                       done,
    output logic [ANGLE_W-1:0]         angle,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    crang_cfg_t cfg_reg, cfg_next;
    crang_vec_t push_vec, head;
    logic       push, pop, full, head_valid;

    // Calibration registers: take any write, ignore unknown indexes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OFFSET_X: cfg_next.offset_x = cfg_data[SAMPLE_W-1:0];
                REG_OFFSET_Y: cfg_next.offset_y = cfg_data[SAMPLE_W-1:0];
                REG_GAIN_X:   cfg_next.gain_x   = cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:   cfg_next.gain_y   = cfg_data[GAIN_W-1:0];
                REG_SIN_SKEW: cfg_next.sin_skew = cfg_data[SKEW_W-1:0];
                REG_SEC_SKEW: cfg_next.sec_skew = cfg_data[SKEW_W-1:0];
                REG_PHASE_X:  cfg_next.phase_x  = cfg_data[ANGLE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.gain_x   <= GAIN_W'(65536);
            cfg_reg.gain_y   <= GAIN_W'(65536);
            cfg_reg.sin_skew <= '0;
            cfg_reg.sec_skew <= SKEW_W'(16384);
            cfg_reg.phase_x  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: offset, gain, skew and secant correction, then classify
    crang_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cos_sample (cos_sample),
        .sin_sample (sin_sample),
        .cfg        (cfg_reg),
        .full       (full),
        .busy       (busy),
        .push       (push),
        .push_vec   (push_vec)
    );

    // Queue: decouple calibration from the CORDIC
    crang_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_vec   (push_vec),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: pipelined CORDIC, phase subtract and rounding
    crang_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .cfg        (cfg_reg),
        .pop        (pop),
        .done       (done),
        .angle      (angle)
    );

endmodule

// ===== hdl/crang_front.sv =====
module crang_front
    import crang_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SAMPLE_W-1:0] cos_sample,
    input  logic signed [SAMPLE_W-1:0] sin_sample,
    input  crang_cfg_t                 cfg,
    input  logic                       full,
    output logic                       busy,
    output logic                       push,
    output crang_vec_t                 push_vec
);

    logic                      en;
    logic [4:0]                vld_reg, vld_next;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg;
    logic signed [X_W-1:0]     x3_reg, y3_reg;
    logic signed [Q_W-1:0]     q_reg;
    logic signed [X_W-1:0]     x4_reg, x5_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [M_W-1:0]     m_reg;
    logic signed [PROD_W-1:0]  px_next, py_next;
    logic signed [Q_W-1:0]     q_next;
    logic signed [D_W-1:0]     ysh, qext, d_next;
    logic signed [YC_W-1:0]    yc;
    logic signed [CW-1:0]      xe, ye;

    // Hold the whole front while the queue is full
    assign en   = !full;
    assign busy = full;
    assign vld_next = {vld_reg[3:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign px_next = dx_reg * $signed({1'b0, cfg.gain_x});
    assign py_next = dy_reg * $signed({1'b0, cfg.gain_y});
    assign q_next  = $signed(px_reg[PROD_W-1:GAIN_SHIFT]) * cfg.sin_skew;
    assign ysh     = {{(D_W-X_W-FRAC_W){y3_reg[X_W-1]}}, y3_reg, {FRAC_W{1'b0}}};
    assign qext    = {q_reg[Q_W-1], q_reg};
    assign d_next  = ysh - qext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DIFF_W'(cos_sample) - DIFF_W'(cfg.offset_x);
            dy_reg <= DIFF_W'(sin_sample) - DIFF_W'(cfg.offset_y);
            px_reg <= px_next;
            py_reg <= py_next;
            x3_reg <= px_reg[PROD_W-1:GAIN_SHIFT];
            y3_reg <= py_reg[PROD_W-1:GAIN_SHIFT];
            q_reg  <= q_next;
            x4_reg <= x3_reg;
            t_reg  <= d_next[D_W-1:FRAC_W];
            x5_reg <= x4_reg;
            m_reg  <= t_reg * $signed({1'b0, cfg.sec_skew});
        end
    end

    // Classify: flag the zero vector, fold the left half plane by pi
    assign yc = m_reg[M_W-1:FRAC_W];
    assign xe = CW'(x5_reg);
    assign ye = CW'(yc);

    always_comb
    begin
        push_vec.zero = (x5_reg == '0) && (yc == '0);
        push_vec.half = x5_reg[X_W-1];
        if (x5_reg[X_W-1])
        begin
            push_vec.x = -xe;
            push_vec.y = -ye;
        end
        else
        begin
            push_vec.x = xe;
            push_vec.y = ye;
        end
    end

    assign push = vld_reg[4] && en;

endmodule

// ===== hdl/crang_fifo.sv =====
module crang_fifo
    import crang_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  crang_vec_t push_vec,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output crang_vec_t head
);

    crang_vec_t          mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_vec;
        end
    end

endmodule

// ===== hdl/crang_back.sv =====
module crang_back
    import crang_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  crang_vec_t         head,
    input  crang_cfg_t         cfg,
    output logic               pop,
    output logic               done,
    output logic [ANGLE_W-1:0] angle
);

    logic signed [CW-1:0] bx_reg [0:NSTEPS];
    logic signed [CW-1:0] by_reg [0:NSTEPS];
    logic [ZW-1:0]        bz_reg [0:NSTEPS];
    logic [NSTEPS:0]      bzero_reg;
    logic [NSTEPS:0]      bv_reg;
    logic [NSTEPS:0]      bv_next;
    logic                 done_reg, done_next;
    logic [ANGLE_W-1:0]   angle_reg, angle_next;
    logic [ZW-1:0]        zf, za;

    // The back end never stalls: take the queue head whenever there is one
    assign pop = head_valid;

    always_comb
    begin
        bv_next = {bv_reg[NSTEPS-1:0], head_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bv_reg   <= bv_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg[0]    <= head.x;
        by_reg[0]    <= head.y;
        bz_reg[0]    <= head.half ? Z_HALF : '0;
        bzero_reg[0] <= head.zero;
    end

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_step
        logic signed [CW-1:0] bx_next, by_next, xs, ys;
        logic [ZW-1:0]        bz_next;

        assign xs = bx_reg[i] >>> i;
        assign ys = by_reg[i] >>> i;

        always_comb
        begin
            if (by_reg[i][CW-1])
            begin
                bx_next = bx_reg[i] - ys;
                by_next = by_reg[i] + xs;
                bz_next = bz_reg[i] - atan_lut(5'(i));
            end
            else
            begin
                bx_next = bx_reg[i] + ys;
                by_next = by_reg[i] - xs;
                bz_next = bz_reg[i] + atan_lut(5'(i));
            end
        end

        always_ff @(posedge clk)
        begin
            bx_reg[i+1]    <= bx_next;
            by_reg[i+1]    <= by_next;
            bz_reg[i+1]    <= bz_next;
            bzero_reg[i+1] <= bzero_reg[i];
        end
    end

    // Drop the CORDIC angle for a zero vector, subtract phase, round to 16 bits
    assign zf         = bzero_reg[NSTEPS] ? '0 : bz_reg[NSTEPS];
    assign za         = zf - {cfg.phase_x, {(ZW-ANGLE_W){1'b0}}} + Z_ROUND;
    assign angle_next = za[ZW-1:ZW-ANGLE_W];
    assign done_next  = bv_reg[NSTEPS];

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            angle_reg <= angle_next;
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

// ===== hdl/crang_check.sv =====
module crang_check
    import crang_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);

    // done is sampled at the edge after it rises, so DONE_LAG reaches from the accepting edge to that sample
    localparam int DONE_LAG = LATENCY + 1;
    localparam int AGE_W    = $clog2(DONE_LAG + 1);

    logic [AGE_W-1:0] age_reg, age_next;

    // Count edges since reset release, saturate at the edge that takes the first done
    assign age_next = (age_reg == AGE_W'(DONE_LAG)) ? age_reg : age_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else
        begin
            age_reg <= age_next;
        end
    end

    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the result side never stalls");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (age_reg == AGE_W'(DONE_LAG)) |-> (done == $past(start && !busy, DONE_LAG)))
        else $error("done does not match a request accepted a fixed latency earlier");

    a_no_done_early: assert property (@(posedge clk) disable iff (!rst_n)
        (age_reg != AGE_W'(DONE_LAG)) |-> !done)
        else $error("done strobe before any request could reach the output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind calibrated_resolver_angle crang_check u_check (.*);
